[src/markov_word_probability_assert.svh]
`ifndef MARKOV_WORD_PROBABILITY_ASSERT_SVH
`define MARKOV_WORD_PROBABILITY_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MWP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MWP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/mwp_pkg.sv]
package mwp_pkg;

    localparam int OP_W       = 2;
    localparam int IDX_W      = 12;
    localparam int PROB_W     = 32;
    localparam int WORD_W     = 32;
    localparam int ORDER_W    = 3;
    localparam int LEN_W      = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [OP_W-1:0] OP_LOAD_PFX = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_TRN = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MARKOV_ORDER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD_LENGTH  = 1'b1;

    localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd1;
    localparam logic [LEN_W-1:0]   LEN_RESET   = 5'd8;

    // 1.0 in Q1.31
    localparam logic [PROB_W-1:0] Q_ONE = 32'h8000_0000;

    typedef enum logic [2:0] {
        STEP_CHECK,
        STEP_FIRST,
        STEP_LOOP,
        STEP_LAST,
        STEP_PFX
    } step_t;

    typedef enum logic [1:0] {
        COND_NONE,
        COND_CNT_ZERO,
        COND_CNT_ONE,
        COND_CNT_MORE
    } cond_t;

    typedef struct packed {
        logic  rd_pfx;
        logic  rd_trn;
        logic  mul_trn;
        logic  mul_pfx;
        logic  finish;
        cond_t cond;
        step_t target;
    } ucode_t;

    // Query program. Jumps are taken on the base count before this step's read.
    function automatic ucode_t ucode_rom(step_t step);
        ucode_t uc;
        begin
            uc = '0;
            unique case (step)
                STEP_CHECK:
                begin
                    uc.rd_pfx = 1'b1;
                    uc.cond   = COND_CNT_ZERO;
                    uc.target = STEP_PFX;
                end
                STEP_FIRST:
                begin
                    uc.rd_trn = 1'b1;
                    uc.cond   = COND_CNT_ONE;
                    uc.target = STEP_LAST;
                end
                STEP_LOOP:
                begin
                    uc.rd_trn  = 1'b1;
                    uc.mul_trn = 1'b1;
                    uc.cond    = COND_CNT_MORE;
                    uc.target  = STEP_LOOP;
                end
                STEP_LAST:
                begin
                    uc.mul_trn = 1'b1;
                end
                STEP_PFX:
                begin
                    uc.mul_pfx = 1'b1;
                    uc.finish  = 1'b1;
                end
                default:
                begin
                    uc.finish = 1'b1;
                end
            endcase
            return uc;
        end
    endfunction

endpackage

[src/markov_word_probability.sv]
// Markov background probability of a DNA word. Loads (op 0 prefix table, op 1
// transition table) raise no busy and no done. A query (op 2) holds busy while
// it walks r transition factors (word_length - markov_order); there are none for a
// word no longer than the model order. A start while busy is high is not taken.
// A query walks the product chain through the single 32x32 multiplier, one
// transition lookup and one multiply per base. The result beat appears on
// word_prob and status with done high for exactly one cycle, the first cycle in
// which busy is low again; there is no back-pressure, so capture it then. A new
// start may be given in that same cycle. Configuration is to be written only while
// busy is low; the block itself does not enforce it.
module markov_word_probability #(
    parameter int MAX_ORDER    = 5,
    parameter int MAX_WORD_LEN = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [mwp_pkg::OP_W-1:0]        op,
    input  logic [mwp_pkg::IDX_W-1:0]       table_index,
    input  logic [mwp_pkg::PROB_W-1:0]      prob_value,
    input  logic [mwp_pkg::WORD_W-1:0]      word,
    output logic                            done,
    output logic [mwp_pkg::PROB_W-1:0]      word_prob,
    output logic                            status,
    input  logic                            cfg_we,
    input  logic [mwp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mwp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import mwp_pkg::*;

    localparam int CTX_W     = 2 * MAX_ORDER;
    localparam int TRN_AW    = CTX_W + 2;
    localparam int PFX_DEPTH = 1 << CTX_W;
    localparam int TRN_DEPTH = 1 << TRN_AW;
    localparam int CNT_W     = $clog2(MAX_WORD_LEN);
    localparam int WL_W      = 2 * MAX_WORD_LEN;
    localparam int EXT_W     = (TRN_AW > IDX_W) ? TRN_AW : IDX_W;

    // control
    logic                 active_reg, active_next;
    step_t                pc_reg, pc_next;
    logic                 done_reg, done_next;
    logic [ORDER_W-1:0]   markov_order_reg, markov_order_next;
    logic [LEN_W-1:0]     word_length_reg, word_length_next;

    // datapath
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CTX_W-1:0]     ctx_reg, ctx_next;
    logic [CTX_W-1:0]     ctx_mask_reg, ctx_mask_next;
    logic [WL_W-1:0]      w_reg, w_next;
    logic [PROB_W-1:0]    acc_reg, acc_next;
    logic                 status_reg, status_next;
    logic [PROB_W-1:0]    word_prob_reg, word_prob_next;
    logic [PROB_W-1:0]    pfx_rdata_reg;
    logic [PROB_W-1:0]    trn_rdata_reg;

    logic [PROB_W-1:0]    pfx_mem [PFX_DEPTH];
    logic [PROB_W-1:0]    trn_mem [TRN_DEPTH];

    ucode_t               uc;
    logic                 jump;
    logic                 accept;
    logic                 accept_query;
    logic                 pfx_we;
    logic                 trn_we;
    logic                 pfx_re;
    logic                 trn_re;
    logic [EXT_W-1:0]     idx_ext;
    logic [PROB_W-1:0]    wdata_sat;

    logic [ORDER_W-1:0]   m_sat;
    logic [LEN_W-1:0]     len_sat;
    logic                 short_word;
    logic [LEN_W-1:0]     rest_full;
    logic [WORD_W-1:0]    len_mask;
    logic [WORD_W-1:0]    w_masked;
    logic [WORD_W-1:0]    first_w;

    logic [CNT_W-1:0]     cnt_dec;
    logic [CNT_W:0]       base_pos;
    logic [1:0]           base;
    logic [TRN_AW-1:0]    trn_raddr;

    logic [PROB_W-1:0]    mul_b;
    logic [2*PROB_W-1:0]  prod;
    logic [PROB_W-1:0]    qprod;

    assign accept       = start && !active_reg;
    assign accept_query = accept && (op == OP_QUERY);
    assign pfx_we       = accept && (op == OP_LOAD_PFX);
    assign trn_we       = accept && (op == OP_LOAD_TRN);
    assign idx_ext      = EXT_W'(table_index);
    assign wdata_sat    = (prob_value > Q_ONE) ? Q_ONE : prob_value;

    assign uc     = ucode_rom(pc_reg);
    assign pfx_re = active_reg && uc.rd_pfx;
    assign trn_re = active_reg && uc.rd_trn;

    // query setup from the configuration
    always_comb
    begin
        m_sat = markov_order_reg;
        if (markov_order_reg == '0)
            m_sat = ORDER_W'(1);
        else if (markov_order_reg > ORDER_W'(MAX_ORDER))
            m_sat = ORDER_W'(MAX_ORDER);
        len_sat = word_length_reg;
        if (word_length_reg == '0)
            len_sat = LEN_W'(1);
        else if (word_length_reg > LEN_W'(MAX_WORD_LEN))
            len_sat = LEN_W'(MAX_WORD_LEN);
    end

    assign short_word = len_sat < LEN_W'(m_sat);
    assign rest_full  = len_sat - LEN_W'(m_sat);
    assign len_mask   = ~({WORD_W{1'b1}} << {len_sat, 1'b0});
    assign w_masked   = word & len_mask;
    assign first_w    = w_masked >> {rest_full, 1'b0};

    // next base and transition address from the sliding context
    assign cnt_dec   = cnt_reg - CNT_W'(1);
    assign base_pos  = {cnt_dec, 1'b0};
    assign base      = w_reg[base_pos +: 2];
    assign trn_raddr = {ctx_reg, base};

    assign mul_b = uc.mul_pfx ? pfx_rdata_reg : trn_rdata_reg;
    assign prod  = (2*PROB_W)'(acc_reg) * (2*PROB_W)'(mul_b);
    assign qprod = prod[2*PROB_W-2:PROB_W-1];

    always_comb
    begin
        unique case (uc.cond)
            COND_NONE:     jump = 1'b0;
            COND_CNT_ZERO: jump = (cnt_reg == '0);
            COND_CNT_ONE:  jump = (cnt_reg == CNT_W'(1));
            COND_CNT_MORE: jump = (cnt_reg != CNT_W'(1));
            default:       jump = 1'b0;
        endcase
    end

    // sequencer and configuration
    always_comb
    begin
        active_next       = active_reg;
        pc_next           = pc_reg;
        done_next         = 1'b0;
        markov_order_next = markov_order_reg;
        word_length_next  = word_length_reg;
        if (accept_query)
        begin
            active_next = 1'b1;
            pc_next     = STEP_CHECK;
        end
        else if (active_reg)
        begin
            if (uc.finish)
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
                pc_next     = STEP_CHECK;
            end
            else if (jump)
            begin
                pc_next = uc.target;
            end
            else
            begin
                pc_next = step_t'(pc_reg + 3'd1);
            end
        end
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MARKOV_ORDER: markov_order_next = cfg_wdata[ORDER_W-1:0];
                CFG_WORD_LENGTH:  word_length_next  = cfg_wdata[LEN_W-1:0];
                default:          ;
            endcase
        end
    end

    // datapath
    always_comb
    begin
        cnt_next       = cnt_reg;
        ctx_next       = ctx_reg;
        ctx_mask_next  = ctx_mask_reg;
        w_next         = w_reg;
        acc_next       = acc_reg;
        status_next    = status_reg;
        word_prob_next = word_prob_reg;
        if (accept_query)
        begin
            // short word has no transition factors, runs the prefix step and is zeroed
            cnt_next      = short_word ? '0 : rest_full[CNT_W-1:0];
            status_next   = short_word;
            ctx_next      = first_w[CTX_W-1:0];
            ctx_mask_next = ~({CTX_W{1'b1}} << {m_sat, 1'b0});
            w_next        = w_masked[WL_W-1:0];
            acc_next      = Q_ONE;
        end
        else if (active_reg)
        begin
            if (uc.rd_trn)
            begin
                cnt_next = cnt_dec;
                ctx_next = trn_raddr[CTX_W-1:0] & ctx_mask_reg;
            end
            if (uc.mul_trn)
                acc_next = qprod;
            if (uc.mul_pfx)
                word_prob_next = status_reg ? '0 : qprod;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg       <= 1'b0;
            pc_reg           <= STEP_CHECK;
            done_reg         <= 1'b0;
            markov_order_reg <= ORDER_RESET;
            word_length_reg  <= LEN_RESET;
        end
        else
        begin
            active_reg       <= active_next;
            pc_reg           <= pc_next;
            done_reg         <= done_next;
            markov_order_reg <= markov_order_next;
            word_length_reg  <= word_length_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg       <= cnt_next;
        ctx_reg       <= ctx_next;
        ctx_mask_reg  <= ctx_mask_next;
        w_reg         <= w_next;
        acc_reg       <= acc_next;
        status_reg    <= status_next;
        word_prob_reg <= word_prob_next;
    end

    always_ff @(posedge clk)
    begin
        if (pfx_we)
            pfx_mem[idx_ext[CTX_W-1:0]] <= wdata_sat;
        if (pfx_re)
            pfx_rdata_reg <= pfx_mem[ctx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (trn_we)
            trn_mem[idx_ext[TRN_AW-1:0]] <= wdata_sat;
        if (trn_re)
            trn_rdata_reg <= trn_mem[trn_raddr];
    end

    assign busy      = active_reg;
    assign done      = done_reg;
    assign word_prob = word_prob_reg;
    assign status    = status_reg;

endmodule

[src/mwp_checker.sv]
`include "markov_word_probability_assert.svh"

module mwp_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic [mwp_pkg::OP_W-1:0]    op,
    input logic                        done,
    input logic [mwp_pkg::PROB_W-1:0]  word_prob,
    input logic                        status
);
    import mwp_pkg::*;

    // a query beat holds busy off the input until its result
    `MWP_ASSERT_NEXT(a_query_busy, start && !busy && (op == OP_QUERY), busy, "query did not raise busy")

    // loads and op three finish in the accepting cycle
    `MWP_ASSERT_NEXT(a_load_quiet, start && !busy && (op != OP_QUERY), !busy && !done, "non-query raised busy or done")

    // the result beat comes exactly as busy drops
    `MWP_ASSERT_NOW(a_done_on_fall, $fell(busy), done, "busy fell without a result beat")
    `MWP_ASSERT_NOW(a_done_idle, done, !busy && !$past(done), "result beat overlaps busy")

    // short word reports zero; any result stays within 1.0
    `MWP_ASSERT_NOW(a_result_range, done, (word_prob <= Q_ONE) && (!status || (word_prob == '0)), "result out of range")

endmodule

bind markov_word_probability mwp_checker u_mwp_checker (.*);
